FILE: rtl/rsrl_pkg.sv
// ----------------------------------------------------------------------------
// rsrl_pkg: shared types and constants for the rumble limiter
// Word formats, configuration registers and state of the limiter.
// ----------------------------------------------------------------------------
package rsrl_pkg;

    localparam int FRAME_BITS = 32;

    localparam logic [15:0] DEADBAND_RST       = 16'd4096;
    localparam logic [7:0]  REARM_INTERVAL_RST = 8'd3;
    localparam logic [9:0]  ACTIVE_WINDOW_RST  = 10'd100;
    localparam logic [3:0]  DECAY_SHIFT_RST    = 4'd4;

    localparam logic [15:0] LEVEL_FULL = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEADBAND       = 2'd0,
        CFG_REARM_INTERVAL = 2'd1,
        CFG_ACTIVE_WINDOW  = 2'd2,
        CFG_DECAY_SHIFT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        cmd;
        logic        pad_connected;
        logic        small_on;
        logic [7:0]  big_level;
        logic [31:0] frame_number;
    } in_word_t;

    typedef struct packed {
        logic        send;
        logic [15:0] low_magnitude;
        logic [15:0] high_magnitude;
        logic [9:0]  duration_ms;
    } out_word_t;

    typedef struct packed {
        logic [15:0] deadband;
        logic [7:0]  rearm_interval;
        logic [9:0]  active_window_ms;
        logic [3:0]  decay_shift;
    } cfg_t;

    typedef struct packed {
        logic [15:0]           sent_low;
        logic [15:0]           sent_high;
        logic [FRAME_BITS-1:0] last_arm_frame;
        logic [15:0]           small_level;
    } state_t;

endpackage

FILE: rtl/rumble_smoothing_rearm_limiter.sv
// ----------------------------------------------------------------------------
// rumble_smoothing_rearm_limiter: per-frame rumble smoothing and re-arm
// Input register, one-pass update, result register with valid/stall flow.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one word per frame tick or
//   device change. Output channel (out_valid / out_stall / out_data): exactly
//   one word per input word, in order; send marks an issued rumble command,
//   and when send is low the magnitude and duration fields read zero.
//   Config port: cfg_wr_en with cfg_index and cfg_data writes one register;
//   write only while no word is in flight.
// Timing:
//   out_valid rises when a word moves from the input register into the
//   result register. Throughput is one word per cycle while out_stall is low:
//   the update is a single pass of narrow adds and compares, and the state
//   registers feed back to it in the same cycle, so consecutive words chain
//   without gaps.
// Reset:
//   rst_n clears both pipeline valids, the limiter state (sent magnitudes,
//   last command frame, smoothed level) and loads the register defaults.
// Back-pressure:
//   With a result held under out_stall, the input register still takes one
//   more word; in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module rumble_smoothing_rearm_limiter
    import rsrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_wr_en,
    input  cfg_index_t cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    logic      in_vld_reg;
    logic      in_vld_next;
    in_word_t  in_data_reg;
    logic      out_vld_reg;
    logic      out_vld_next;
    out_word_t out_data_reg;
    out_word_t result;
    logic      in_take;
    logic      advance;

    // the held word moves on when the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    rsrl_update u_update (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .word       (in_data_reg),
        .result     (result),
        .state_next (state_next)
    );

    always_comb
    begin
        priority if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_comb
    begin
        priority if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband         <= DEADBAND_RST;
            cfg_reg.rearm_interval   <= REARM_INTERVAL_RST;
            cfg_reg.active_window_ms <= ACTIVE_WINDOW_RST;
            cfg_reg.decay_shift      <= DECAY_SHIFT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEADBAND:       cfg_reg.deadband         <= cfg_data;
                CFG_REARM_INTERVAL: cfg_reg.rearm_interval   <= cfg_data[7:0];
                CFG_ACTIVE_WINDOW:  cfg_reg.active_window_ms <= cfg_data[9:0];
                CFG_DECAY_SHIFT:    cfg_reg.decay_shift      <= cfg_data[3:0];
                default:            cfg_reg.deadband         <= cfg_reg.deadband;
            endcase
        end
    end

    // control: valids and limiter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTH
    // a silent word carries no magnitudes or duration
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.send |->
            out_data.low_magnitude == 16'd0 && out_data.high_magnitude == 16'd0
            && out_data.duration_ms == 10'd0)
        else $error("silent word has nonzero fields");

    // a stop command has zero duration
    a_stop_duration: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send && out_data.low_magnitude == 16'd0
            && out_data.high_magnitude == 16'd0 |-> out_data.duration_ms == 10'd0)
        else $error("stop command with nonzero duration");

    // device change clears the smoothed level and sent magnitudes
    a_dev_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.cmd |=>
            state_reg.small_level == 16'd0 && state_reg.sent_low == 16'd0
            && state_reg.sent_high == 16'd0)
        else $error("device change did not clear state");

    // back-pressure only with both stages full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg)
        else $error("input stalled with a free stage");

    // a sent word records its magnitudes as the new reference
    a_sent_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.send |=>
            state_reg.sent_low == out_data_reg.low_magnitude
            && state_reg.sent_high == out_data_reg.high_magnitude)
        else $error("sent magnitudes not recorded");
`endif

endmodule

FILE: rtl/rsrl_update.sv
// ----------------------------------------------------------------------------
// rsrl_update: one-frame update of the rumble limiter
// Smooths the small motor level, decides on a send and forms the next state.
// ----------------------------------------------------------------------------
module rsrl_update
    import rsrl_pkg::*;
(
    input  cfg_t      cfg,
    input  state_t    state,
    input  in_word_t  word,
    output out_word_t result,
    output state_t    state_next
);

    logic [15:0]           low;
    logic                  level_clear;
    logic [15:0]           rise_level;
    logic [15:0]           round_mask;
    logic [16:0]           fall_sum;
    logic [15:0]           fall_step;
    logic [15:0]           fall_level;
    logic [15:0]           level_new;
    logic                  now_zero;
    logic                  was_zero;
    logic [15:0]           diff_low;
    logic [15:0]           diff_high;
    logic                  changed;
    logic [FRAME_BITS-1:0] frame;
    logic [FRAME_BITS-1:0] elapsed;
    logic                  rearm;
    logic                  fire;

    assign low         = {word.big_level, word.big_level};
    assign level_clear = (word.big_level == 8'd0) && !word.small_on;

    // rising: floor step toward full scale; falling: rounded-up step to zero
    assign rise_level = state.small_level + ((LEVEL_FULL - state.small_level) >> cfg.decay_shift);
    assign round_mask = ~(LEVEL_FULL << cfg.decay_shift);
    assign fall_sum   = {1'b0, state.small_level} + {1'b0, round_mask};
    assign fall_step  = 16'(fall_sum >> cfg.decay_shift);
    assign fall_level = state.small_level - fall_step;

    always_comb
    begin
        priority if (level_clear)
        begin
            level_new = 16'd0;
        end
        else if (word.small_on)
        begin
            level_new = rise_level;
        end
        else
        begin
            level_new = fall_level;
        end
    end

    assign now_zero  = (low == 16'd0) && (level_new == 16'd0);
    assign was_zero  = (state.sent_low == 16'd0) && (state.sent_high == 16'd0);
    assign diff_low  = (low >= state.sent_low) ? (low - state.sent_low)
                                               : (state.sent_low - low);
    assign diff_high = (level_new >= state.sent_high) ? (level_new - state.sent_high)
                                                      : (state.sent_high - level_new);
    assign changed   = (now_zero != was_zero) || (diff_low > cfg.deadband)
                    || (diff_high > cfg.deadband);

    assign frame   = FRAME_BITS'(word.frame_number);
    assign elapsed = frame - state.last_arm_frame;
    assign rearm   = !now_zero && (elapsed >= FRAME_BITS'(cfg.rearm_interval));
    assign fire    = changed || rearm;

    always_comb
    begin
        result     = '0;
        state_next = state;
        priority if (word.cmd)
        begin
            // device change: forget sent values and the smoothed level
            state_next.sent_low    = 16'd0;
            state_next.sent_high   = 16'd0;
            state_next.small_level = 16'd0;
        end
        else if (word.pad_connected)
        begin
            state_next.small_level = level_new;
            if (fire)
            begin
                result.send              = 1'b1;
                result.low_magnitude     = low;
                result.high_magnitude    = level_new;
                result.duration_ms       = now_zero ? 10'd0 : cfg.active_window_ms;
                state_next.sent_low       = low;
                state_next.sent_high      = level_new;
                state_next.last_arm_frame = frame;
            end
        end
    end

endmodule
